/* rtl/core/bil_pkg.sv */
// bil_pkg: shared types, field widths and codes for the bilinear RGBA scaler.
// No dependencies; used by every file under rtl/core.
package bil_pkg;

   localparam int MAX_SRC_WIDTH_DEF  = 512;
   localparam int MAX_SRC_HEIGHT_DEF = 512;
   localparam int FRAC_BITS_DEF      = 16;

   localparam int COORD_W    = 12;
   localparam int SRC_DIM_W  = 10;
   localparam int DST_DIM_W  = 13;
   localparam int SIZE_W     = 13;
   localparam int STEP_W     = 26;
   localparam int CH_W       = 8;
   localparam int PIX_W      = 4 * CH_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 26;

   localparam logic FUNC_STORE   = 1'b0;
   localparam logic FUNC_REQUEST = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_X_STEP     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_STEP     = 3'd5;

   typedef struct packed {
      logic              func;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [CH_W-1:0]   red_in;
      logic [CH_W-1:0]   green_in;
      logic [CH_W-1:0]   blue_in;
      logic [CH_W-1:0]   alpha_in;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0] red_out;
      logic [CH_W-1:0] green_out;
      logic [CH_W-1:0] blue_out;
      logic [CH_W-1:0] alpha_out;
      logic            range_error;
   } rsp_type;

   // four neighbors, each packed R in [7:0] .. A in [31:24]
   typedef struct packed {
      logic [PIX_W-1:0] p00;
      logic [PIX_W-1:0] p10;
      logic [PIX_W-1:0] p01;
      logic [PIX_W-1:0] p11;
   } quad_type;

endpackage

/* rtl/core/bil_axis.sv */
// bil_axis: two-stage source coordinate locator for one axis (multiply, then floor/clamp).
// Depends on bil_pkg.
module bil_axis #(
   parameter int MAX_SIZE  = bil_pkg::MAX_SRC_WIDTH_DEF,
   parameter int FRAC_BITS = bil_pkg::FRAC_BITS_DEF,
   parameter int IW        = 9
) (
   input  logic                            clock,
   input  logic                            en1,
   input  logic                            en2,
   input  logic [bil_pkg::COORD_W-1:0]     pos,
   input  logic [bil_pkg::STEP_W-1:0]      step,
   input  logic [bil_pkg::SIZE_W-1:0]      size,
   output logic [IW-1:0]                   i0,
   output logic [IW-1:0]                   i1,
   output logic [FRAC_BITS:0]              frac
);
   localparam int PW = bil_pkg::COORD_W + 1 + bil_pkg::STEP_W;
   localparam int HW = PW - 1;

   logic [PW-1:0]      prod_ff, prod_in;
   logic [HW-1:0]      half, s, ip, lim, lo;
   logic               neg, clamped;
   logic [IW-1:0]      i0_ff, i1_ff, i0_in, i1_in;
   logic [FRAC_BITS:0] frac_ff, frac_in;

   assign prod_in = PW'({pos, 1'b1}) * PW'(step);

   always_comb begin
      half    = prod_ff[PW-1:1];
      neg     = half < (HW'(1) << (FRAC_BITS - 1));
      s       = half - (HW'(1) << (FRAC_BITS - 1));
      ip      = s >> FRAC_BITS;
      lim     = HW'(size - bil_pkg::SIZE_W'(1));
      clamped = ip > lim;
      if (neg) begin
         lo      = '0;
         frac_in = '0;
      end else if (clamped) begin
         lo      = lim;
         frac_in = (FRAC_BITS+1)'(1) << FRAC_BITS;
      end else begin
         lo      = ip;
         frac_in = {1'b0, s[FRAC_BITS-1:0]};
      end
      i0_in = lo[IW-1:0];
      i1_in = (lo == lim) ? lim[IW-1:0] : IW'(lo + HW'(1));
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         prod_ff <= prod_in;
      end
      if (en2) begin
         i0_ff   <= i0_in;
         i1_ff   <= i1_in;
         frac_ff <= frac_in;
      end
   end

   assign i0   = i0_ff;
   assign i1   = i1_ff;
   assign frac = frac_ff;
endmodule

/* rtl/core/bil_fstore.sv */
// bil_fstore: frame store split into four banks by column and row parity,
// one write and four neighbor reads per cycle when we and re are set. Depends on bil_pkg.
module bil_fstore #(
   parameter int MAX_SRC_WIDTH  = bil_pkg::MAX_SRC_WIDTH_DEF,
   parameter int MAX_SRC_HEIGHT = bil_pkg::MAX_SRC_HEIGHT_DEF,
   parameter int XW             = 9,
   parameter int YW             = 9
) (
   input  logic                        clock,
   input  logic                        we,
   input  logic [XW-1:0]               wcol,
   input  logic [YW-1:0]               wrow,
   input  logic [bil_pkg::PIX_W-1:0]   wdata,
   input  logic                        re,
   input  logic [XW-1:0]               x0,
   input  logic [XW-1:0]               x1,
   input  logic [YW-1:0]               y0,
   input  logic [YW-1:0]               y1,
   output bil_pkg::quad_type           quad
);
   localparam int HALF_W = (MAX_SRC_WIDTH + 1) / 2;
   localparam int HALF_H = (MAX_SRC_HEIGHT + 1) / 2;
   localparam int DEPTH  = HALF_W * HALF_H;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   function automatic logic [AW-1:0] bank_addr(input logic [XW-1:0] x,
                                               input logic [YW-1:0] y);
      logic [31:0] t;
      t = 32'(y >> 1) * 32'(HALF_W) + 32'(x >> 1);
      return t[AW-1:0];
   endfunction

   logic [XW-1:0]             xsel [2];
   logic [YW-1:0]             ysel [2];
   logic [bil_pkg::PIX_W-1:0] rd_ff [4];
   logic [3:0]                par_ff, par_in;
   logic [AW-1:0]             waddr;
   logic [1:0]                wbank;

   // even/odd column and row that each bank pair must serve
   always_comb begin
      xsel[0] = x0[0] ? x1 : x0;
      xsel[1] = x0[0] ? x0 : x1;
      ysel[0] = y0[0] ? y1 : y0;
      ysel[1] = y0[0] ? y0 : y1;
      par_in  = {y1[0], y0[0], x1[0], x0[0]};
      waddr   = bank_addr(wcol, wrow);
      wbank   = {wrow[0], wcol[0]};
   end

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [bil_pkg::PIX_W-1:0] mem [DEPTH];
      always_ff @(posedge clock) begin
         if (we && (wbank == 2'(b))) begin
            mem[waddr] <= wdata;
         end
         if (re) begin
            rd_ff[b] <= mem[bank_addr(xsel[b % 2], ysel[b / 2])];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         par_ff <= par_in;
      end
   end

   always_comb begin
      quad.p00 = rd_ff[{par_ff[2], par_ff[0]}];
      quad.p10 = rd_ff[{par_ff[2], par_ff[1]}];
      quad.p01 = rd_ff[{par_ff[3], par_ff[0]}];
      quad.p11 = rd_ff[{par_ff[3], par_ff[1]}];
   end
endmodule

/* rtl/core/bil_blend.sv */
// bil_blend: two-stage per-channel interpolation, horizontal then vertical with rounding;
// channels saturate at 255 and read zero on a range error. Depends on bil_pkg.
module bil_blend #(
   parameter int FRAC_BITS = bil_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                en4,
   input  logic                en5,
   input  bil_pkg::quad_type   quad,
   input  logic [FRAC_BITS:0]  fx,
   input  logic [FRAC_BITS:0]  fy,
   input  logic                err,
   output bil_pkg::rsp_type    data
);
   localparam int TW = FRAC_BITS + 8;
   localparam int VW = 2 * FRAC_BITS + 9;
   localparam int CW = bil_pkg::CH_W;

   logic [TW-1:0]      top_ff [4], bot_ff [4], top_in [4], bot_in [4];
   logic [FRAC_BITS:0] fy_ff, wx0, wy0;
   logic               err_ff;
   logic [CW-1:0]      ch [4];
   logic [VW-1:0]      v [4];
   bil_pkg::rsp_type   data_ff, data_in;

   always_comb begin
      wx0 = ((FRAC_BITS+1)'(1) << FRAC_BITS) - fx;
      wy0 = ((FRAC_BITS+1)'(1) << FRAC_BITS) - fy_ff;
      for (int c = 0; c < 4; c++) begin
         top_in[c] = TW'(TW'(quad.p00[c*CW +: CW]) * TW'(wx0)
                       + TW'(quad.p10[c*CW +: CW]) * TW'(fx));
         bot_in[c] = TW'(TW'(quad.p01[c*CW +: CW]) * TW'(wx0)
                       + TW'(quad.p11[c*CW +: CW]) * TW'(fx));
      end
      for (int c = 0; c < 4; c++) begin
         v[c] = VW'(top_ff[c]) * VW'(wy0) + VW'(bot_ff[c]) * VW'(fy_ff)
                + (VW'(1) << (2 * FRAC_BITS - 1));
         v[c] = v[c] >> (2 * FRAC_BITS);
         ch[c] = (v[c] > VW'(255)) ? 8'hFF : v[c][CW-1:0];
         if (err_ff) begin
            ch[c] = '0;
         end
      end
      data_in.red_out     = ch[0];
      data_in.green_out   = ch[1];
      data_in.blue_out    = ch[2];
      data_in.alpha_out   = ch[3];
      data_in.range_error = err_ff;
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         top_ff <= top_in;
         bot_ff <= bot_in;
         fy_ff  <= fy;
         err_ff <= err;
      end
      if (en5) begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;
endmodule

/* rtl/core/bilinear_rgba_scaler_top.sv */
// Channel   Ports               Carries
// request   req_valid/ready     req_data: store a source pixel or ask for an output pixel
// response  rsp_valid/ready     rsp_data: interpolated RGBA and range flag
// config    csr_we/index/wdata  geometry and step registers, write only
//
// Five register stages: multiply, locate, frame store read, horizontal mix,
// vertical mix. One transaction per cycle unless the response side stalls;
// the four-bank frame store serves all four neighbors in a single read.
// Stages move on independently, so bubbles close up under a response stall.
// Synchronous reset clears valids and sets config to its defaults; frame store is undefined until written.
// Depends on bil_pkg, bil_axis, bil_fstore, bil_blend.
module bilinear_rgba_scaler_top #(
   parameter int MAX_SRC_WIDTH  = bil_pkg::MAX_SRC_WIDTH_DEF,
   parameter int MAX_SRC_HEIGHT = bil_pkg::MAX_SRC_HEIGHT_DEF,
   parameter int FRAC_BITS      = bil_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bil_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bil_pkg::rsp_type                  rsp_data,
   input  logic                              csr_we,
   input  logic [bil_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bil_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   localparam int XW = (MAX_SRC_WIDTH > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
   localparam int YW = (MAX_SRC_HEIGHT > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
   localparam int SW = bil_pkg::SIZE_W;

   logic [bil_pkg::SRC_DIM_W-1:0] src_width_ff, src_height_ff;
   logic [bil_pkg::DST_DIM_W-1:0] dst_width_ff, dst_height_ff;
   logic [bil_pkg::STEP_W-1:0]    x_step_ff, y_step_ff;
   logic [SW-1:0]                 w_eff, h_eff;

   logic en1, en2, en3, en4, en5;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic func1_ff, func2_ff, err1_ff, err2_ff, err3_ff, err_in;
   logic [bil_pkg::COORD_W-1:0] col1_ff, row1_ff, col2_ff, row2_ff;
   logic [bil_pkg::PIX_W-1:0]   pix1_ff, pix2_ff;
   logic [FRAC_BITS:0]          fx2, fy2, fx3_ff, fy3_ff;
   logic [XW-1:0]               x0, x1;
   logic [YW-1:0]               y0, y1;
   logic                        store_we;
   bil_pkg::quad_type           quad;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= 10'd512;
         src_height_ff <= 10'd512;
         dst_width_ff  <= 13'd512;
         dst_height_ff <= 13'd512;
         x_step_ff     <= bil_pkg::STEP_W'(1) << FRAC_BITS;
         y_step_ff     <= bil_pkg::STEP_W'(1) << FRAC_BITS;
      end else if (csr_we) begin
         case (csr_index)
            bil_pkg::CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata[bil_pkg::SRC_DIM_W-1:0];
            bil_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_wdata[bil_pkg::SRC_DIM_W-1:0];
            bil_pkg::CSR_DST_WIDTH:  dst_width_ff  <= csr_wdata[bil_pkg::DST_DIM_W-1:0];
            bil_pkg::CSR_DST_HEIGHT: dst_height_ff <= csr_wdata[bil_pkg::DST_DIM_W-1:0];
            bil_pkg::CSR_X_STEP:     x_step_ff     <= csr_wdata[bil_pkg::STEP_W-1:0];
            bil_pkg::CSR_Y_STEP:     y_step_ff     <= csr_wdata[bil_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // zero acts as one, oversize acts as the store dimension
   always_comb begin
      if (src_width_ff == '0) begin
         w_eff = SW'(1);
      end else if (SW'(src_width_ff) > SW'(MAX_SRC_WIDTH)) begin
         w_eff = SW'(MAX_SRC_WIDTH);
      end else begin
         w_eff = SW'(src_width_ff);
      end
      if (src_height_ff == '0) begin
         h_eff = SW'(1);
      end else if (SW'(src_height_ff) > SW'(MAX_SRC_HEIGHT)) begin
         h_eff = SW'(MAX_SRC_HEIGHT);
      end else begin
         h_eff = SW'(src_height_ff);
      end
   end

   assign en5 = !v5_ff || rsp_ready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ready = en1;

   assign err_in = (bil_pkg::DST_DIM_W'(req_data.col) >= dst_width_ff) ||
                   (bil_pkg::DST_DIM_W'(req_data.row) >= dst_height_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         // stores retire at the frame store; only requests go on
         if (en3) v3_ff <= v2_ff && (func2_ff == bil_pkg::FUNC_REQUEST);
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         func1_ff <= req_data.func;
         col1_ff  <= req_data.col;
         row1_ff  <= req_data.row;
         pix1_ff  <= {req_data.alpha_in, req_data.blue_in,
                      req_data.green_in, req_data.red_in};
         err1_ff  <= err_in;
      end
      if (en2) begin
         func2_ff <= func1_ff;
         col2_ff  <= col1_ff;
         row2_ff  <= row1_ff;
         pix2_ff  <= pix1_ff;
         err2_ff  <= err1_ff;
      end
      if (en3) begin
         fx3_ff  <= fx2;
         fy3_ff  <= fy2;
         err3_ff <= err2_ff;
      end
   end

   bil_axis #(.MAX_SIZE(MAX_SRC_WIDTH), .FRAC_BITS(FRAC_BITS), .IW(XW)) u_axis_x (
      .clock (clock),
      .en1   (en1),
      .en2   (en2),
      .pos   (req_data.col),
      .step  (x_step_ff),
      .size  (w_eff),
      .i0    (x0),
      .i1    (x1),
      .frac  (fx2)
   );

   bil_axis #(.MAX_SIZE(MAX_SRC_HEIGHT), .FRAC_BITS(FRAC_BITS), .IW(YW)) u_axis_y (
      .clock (clock),
      .en1   (en1),
      .en2   (en2),
      .pos   (req_data.row),
      .step  (y_step_ff),
      .size  (h_eff),
      .i0    (y0),
      .i1    (y1),
      .frac  (fy2)
   );

   assign store_we = en3 && v2_ff && (func2_ff == bil_pkg::FUNC_STORE) &&
                     (32'(col2_ff) < 32'(MAX_SRC_WIDTH)) &&
                     (32'(row2_ff) < 32'(MAX_SRC_HEIGHT));

   bil_fstore #(
      .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
      .XW             (XW),
      .YW             (YW)
   ) u_fstore (
      .clock (clock),
      .we    (store_we),
      .wcol  (col2_ff[XW-1:0]),
      .wrow  (row2_ff[YW-1:0]),
      .wdata (pix2_ff),
      .re    (en3),
      .x0    (x0),
      .x1    (x1),
      .y0    (y0),
      .y1    (y1),
      .quad  (quad)
   );

   bil_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
      .clock (clock),
      .en4   (en4),
      .en5   (en5),
      .quad  (quad),
      .fx    (fx3_ff),
      .fy    (fy3_ff),
      .err   (err3_ff),
      .data  (rsp_data)
   );

   assign rsp_valid = v5_ff;

`ifndef SYNTHESIS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.range_error |->
         (rsp_data.red_out == '0) && (rsp_data.green_out == '0) &&
         (rsp_data.blue_out == '0) && (rsp_data.alpha_out == '0))
      else $error("range error response with nonzero channels");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v1_ff)
      else $error("accepted transaction lost at first stage");

   a_ready_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> v1_ff && v2_ff && v3_ff && v4_ff && v5_ff)
      else $error("request stalled while pipeline has a bubble");

   a_no_store_retire: assert property (@(posedge clock) disable iff (reset)
      store_we |=> !v3_ff)
      else $error("store transaction passed the frame store stage");
`endif
endmodule

/* bench/bilinear_rgba_scaler_checker.sv */
// Checker for the bilinear RGBA scaler: watches the request, response and register ports,
// predicts each response and compares it field by field. Depends on bil_pkg.
module bilinear_rgba_scaler_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  bil_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  bil_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [bil_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bil_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             pending,
   output int                             fails
);

   localparam int     IMG_W  = bil_pkg::MAX_SRC_WIDTH_DEF;
   localparam int     IMG_H  = bil_pkg::MAX_SRC_HEIGHT_DEF;
   localparam int     FB     = bil_pkg::FRAC_BITS_DEF;
   localparam int     CHW    = bil_pkg::CH_W;
   localparam longint Q_ONE  = 64'd1 << FB;
   localparam longint Q_HALF = 64'd1 << (FB - 1);

   logic [bil_pkg::PIX_W-1:0]     pix_mem [0:IMG_W*IMG_H-1];
   logic [bil_pkg::SRC_DIM_W-1:0] src_w, src_h;
   logic [bil_pkg::DST_DIM_W-1:0] dst_w, dst_h;
   logic [bil_pkg::STEP_W-1:0]    step_x, step_y;
   bil_pkg::rsp_type              expected_pixels [$];
   int                            outstanding;
   int                            fail_count;

   assign pending = outstanding;
   assign fails   = fail_count;

   initial begin
      outstanding = 0;
      fail_count  = 0;
   end

   function automatic int clip_size(input int v, input int lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
   endfunction

   // source position -> clamped base index, neighbor, fraction in Q16
   function automatic void locate(input logic [bil_pkg::COORD_W-1:0] pos,
                                  input logic [bil_pkg::STEP_W-1:0] step,
                                  input int size, output int i0, output int i1,
                                  output longint frac);
      longint s, lo;
      s = longint'(((64'(pos) * 2 + 1) * 64'(step)) >> 1) - Q_HALF;
      if (s < 0) lo = 0;
      else begin
         lo = s >>> FB;
         if (lo > size - 1) lo = size - 1;
      end
      frac = s - lo * Q_ONE;
      if (frac < 0) frac = 0;
      if (frac > Q_ONE) frac = Q_ONE;
      i0 = int'(lo);
      i1 = (i0 + 1 < size) ? i0 + 1 : size - 1;
   endfunction

   function automatic bil_pkg::rsp_type scaled_pixel(input bil_pkg::req_type t);
      bil_pkg::rsp_type r;
      int x0, x1, y0, y1;
      longint fx, fy, a, b, d, e, upper, lower, v;
      logic [bil_pkg::PIX_W-1:0] p00, p10, p01, p11;
      r = '0;
      if (t.col >= dst_w || t.row >= dst_h) begin
         r.range_error = 1'b1;
         return r;
      end
      locate(t.col, step_x, clip_size(src_w, IMG_W), x0, x1, fx);
      locate(t.row, step_y, clip_size(src_h, IMG_H), y0, y1, fy);
      p00 = pix_mem[y0*IMG_W + x0];
      p10 = pix_mem[y0*IMG_W + x1];
      p01 = pix_mem[y1*IMG_W + x0];
      p11 = pix_mem[y1*IMG_W + x1];
      for (int c = 0; c < 4; c++) begin
         a = p00[c*CHW +: CHW];
         b = p10[c*CHW +: CHW];
         d = p01[c*CHW +: CHW];
         e = p11[c*CHW +: CHW];
         upper = a * (Q_ONE - fx) + b * fx;
         lower = d * (Q_ONE - fx) + e * fx;
         v = upper * (Q_ONE - fy) + lower * fy;
         v = (v + (64'd1 << (2*FB - 1))) >> (2*FB);
         if (v > 255) v = 255;
         case (c)
            0: r.red_out   = v[7:0];
            1: r.green_out = v[7:0];
            2: r.blue_out  = v[7:0];
            default: r.alpha_out = v[7:0];
         endcase
      end
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("mismatch %s: got %0d want %0d", field, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      bil_pkg::rsp_type want;
      int      n;
      n = outstanding;
      if (reset) begin
         src_w  <= 10'd512;
         src_h  <= 10'd512;
         dst_w  <= 13'd512;
         dst_h  <= 13'd512;
         step_x <= 26'(Q_ONE);
         step_y <= 26'(Q_ONE);
         expected_pixels.delete();
         n = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               bil_pkg::CSR_SRC_WIDTH:  src_w  <= csr_wdata[bil_pkg::SRC_DIM_W-1:0];
               bil_pkg::CSR_SRC_HEIGHT: src_h  <= csr_wdata[bil_pkg::SRC_DIM_W-1:0];
               bil_pkg::CSR_DST_WIDTH:  dst_w  <= csr_wdata[bil_pkg::DST_DIM_W-1:0];
               bil_pkg::CSR_DST_HEIGHT: dst_h  <= csr_wdata[bil_pkg::DST_DIM_W-1:0];
               bil_pkg::CSR_X_STEP:     step_x <= csr_wdata;
               bil_pkg::CSR_Y_STEP:     step_y <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               want = expected_pixels.pop_front();
               n--;
               if (rsp_data.red_out !== want.red_out)
                  report_mismatch("red_out", rsp_data.red_out, want.red_out);
               if (rsp_data.green_out !== want.green_out)
                  report_mismatch("green_out", rsp_data.green_out, want.green_out);
               if (rsp_data.blue_out !== want.blue_out)
                  report_mismatch("blue_out", rsp_data.blue_out, want.blue_out);
               if (rsp_data.alpha_out !== want.alpha_out)
                  report_mismatch("alpha_out", rsp_data.alpha_out, want.alpha_out);
               if (rsp_data.range_error !== want.range_error)
                  report_mismatch("range_error", rsp_data.range_error, want.range_error);
            end
         end
         if (req_valid && req_ready) begin
            if (req_data.func == bil_pkg::FUNC_STORE) begin
               if (req_data.col < IMG_W && req_data.row < IMG_H)
                  pix_mem[req_data.row*IMG_W + req_data.col] <=
                     {req_data.alpha_in, req_data.blue_in, req_data.green_in, req_data.red_in};
            end else begin
               expected_pixels.push_back(scaled_pixel(req_data));
               n++;
            end
         end
      end
      outstanding <= n;
   end

endmodule

/* bench/bilinear_rgba_scaler_top_tb.sv */
// Testbench top for bilinear_rgba_scaler_top: clock, reset, register setup, stimulus and verdict.
// Depends on bil_pkg, the scaler RTL and bilinear_rgba_scaler_checker.
module bilinear_rgba_scaler_top_tb;

   localparam int IMG_W       = bil_pkg::MAX_SRC_WIDTH_DEF;
   localparam int IMG_H       = bil_pkg::MAX_SRC_HEIGHT_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DW          = bil_pkg::CSR_DATA_W;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   bil_pkg::req_type               req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   bil_pkg::rsp_type               rsp_data;
   logic                           csr_we    = 1'b0;
   logic [bil_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [bil_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   int                             pending;
   int                             fails;

   bit  written_map [0:IMG_W*IMG_H-1];
   bit  allow_gaps = 1'b1;
   int  cycles = 0;
   int  stall_left = 0;
   int  cur_sw = 512, cur_sh = 512, cur_dw = 512, cur_dh = 512;
   int  cur_xs = 65536, cur_ys = 65536;

   always #4 clock = ~clock;

   bilinear_rgba_scaler_top DUT (.*);

   bilinear_rgba_scaler_checker chk (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // response-side backpressure in bursts
   always @(posedge clock) begin
      if (!allow_gaps) rsp_ready <= 1'b1;
      else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 14);
         rsp_ready  <= 1'b0;
      end else rsp_ready <= 1'b1;
   end

   function automatic int clip_size(input int v, input int lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
   endfunction

   // base source index a destination coordinate maps to
   function automatic int base_index(input int pos, input int step, input int size);
      longint s;
      s = longint'(((longint'(pos) * 2 + 1) * longint'(step)) >> 1) - 32768;
      if (s < 0) return 0;
      s = s >>> bil_pkg::FRAC_BITS_DEF;
      return (s > size - 1) ? size - 1 : int'(s);
   endfunction

   task automatic send_item(input bil_pkg::req_type t);
      if (allow_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   task automatic store_pixel(input int c, input int r, input logic [bil_pkg::PIX_W-1:0] rgba);
      bil_pkg::req_type t;
      t = '0;
      t.func = bil_pkg::FUNC_STORE;
      t.col  = bil_pkg::COORD_W'(c);
      t.row  = bil_pkg::COORD_W'(r);
      {t.alpha_in, t.blue_in, t.green_in, t.red_in} = rgba;
      if (c < IMG_W && r < IMG_H) written_map[r*IMG_W + c] = 1'b1;
      send_item(t);
   endtask

   task automatic fill_if_blank(input int c, input int r);
      if (!written_map[r*IMG_W + c]) store_pixel(c, r, $urandom);
   endtask

   task automatic ask_pixel(input int c, input int r);
      bil_pkg::req_type t;
      int w, h, x0, y0, x1, y1;
      if (c < cur_dw && r < cur_dh) begin
         w  = clip_size(cur_sw, IMG_W);
         h  = clip_size(cur_sh, IMG_H);
         x0 = base_index(c, cur_xs, w);
         y0 = base_index(r, cur_ys, h);
         x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
         y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
         fill_if_blank(x0, y0);
         fill_if_blank(x1, y0);
         fill_if_blank(x0, y1);
         fill_if_blank(x1, y1);
      end
      t = '0;
      {t.alpha_in, t.blue_in, t.green_in, t.red_in} = $urandom;
      t.func = bil_pkg::FUNC_REQUEST;
      t.col  = bil_pkg::COORD_W'(c);
      t.row  = bil_pkg::COORD_W'(r);
      send_item(t);
   endtask

   // wait out all responses, then let stores still in flight retire
   task automatic drain;
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic program_regs(input int sw, input int sh, input int dw, input int dh,
                               input int xs, input int ys);
      csr_we <= 1'b1;
      csr_index <= bil_pkg::CSR_SRC_WIDTH;  csr_wdata <= DW'(sw); @(posedge clock);
      csr_index <= bil_pkg::CSR_SRC_HEIGHT; csr_wdata <= DW'(sh); @(posedge clock);
      csr_index <= bil_pkg::CSR_DST_WIDTH;  csr_wdata <= DW'(dw); @(posedge clock);
      csr_index <= bil_pkg::CSR_DST_HEIGHT; csr_wdata <= DW'(dh); @(posedge clock);
      csr_index <= bil_pkg::CSR_X_STEP;     csr_wdata <= DW'(xs); @(posedge clock);
      csr_index <= bil_pkg::CSR_Y_STEP;     csr_wdata <= DW'(ys); @(posedge clock);
      csr_we <= 1'b0;
      cur_sw = sw & 10'h3FF;  cur_sh = sh & 10'h3FF;
      cur_dw = dw & 13'h1FFF; cur_dh = dh & 13'h1FFF;
      cur_xs = xs & 26'h3FFFFFF; cur_ys = ys & 26'h3FFFFFF;
   endtask

   task automatic random_pass(input int count);
      int k, c, r, dwl, dhl;
      for (int i = 0; i < count; i++) begin
         k   = $urandom_range(0, 99);
         dwl = (cur_dw > 4096) ? 4096 : cur_dw;
         dhl = (cur_dh > 4096) ? 4096 : cur_dh;
         if (k < 60 && dwl > 0 && dhl > 0)
            ask_pixel($urandom_range(0, dwl - 1), $urandom_range(0, dhl - 1));
         else if (k < 75)
            ask_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
         else begin
            if ($urandom_range(0, 1)) begin
               c = $urandom_range(0, 4095);
               r = $urandom_range(0, 4095);
            end else begin
               c = $urandom_range(0, clip_size(cur_sw, IMG_W) - 1);
               r = $urandom_range(0, clip_size(cur_sh, IMG_H) - 1);
            end
            store_pixel(c, r, $urandom);
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 2x2 source upscaled to 4x4
      program_regs(2, 2, 4, 4, 32768, 32768);
      store_pixel(0, 0, 32'h0000_0000);
      store_pixel(1, 0, 32'hFFFF_FFFF);
      store_pixel(0, 1, 32'h80FF_0001);
      store_pixel(1, 1, 32'h7F00_FFFE);
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            ask_pixel(c, r);
      ask_pixel(4, 0);
      ask_pixel(0, 4);
      ask_pixel(4095, 4095);
      store_pixel(4095, 4095, 32'h1234_5678);
      store_pixel(512, 0, 32'hA5A5_A5A5);
      store_pixel(0, 512, 32'h5A5A_5A5A);
      drain();

      program_regs(512, 512, 512, 512, 65536, 65536);
      random_pass(45);
      drain();
      program_regs(1, 1, 4096, 4096, 16, 16);
      random_pass(50);
      drain();
      program_regs(512, 1, 1, 512, 33554432, 65536);
      random_pass(50);
      drain();
      // size registers out of range, zero step, wide destination
      program_regs(0, 1023, 8191, 100, 0, 3000000);
      random_pass(45);
      drain();
      for (int p = 0; p < 4; p++) begin
         program_regs($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 40),
                      $urandom_range(1, 40), $urandom_range(16, 300000),
                      $urandom_range(16, 300000));
         random_pass(20);
         drain();
         random_pass(20);
         drain();
      end
      allow_gaps = 1'b0;
      program_regs(7, 5, 19, 13, 24145, 25206);
      random_pass(60);
      drain();

      if (fails == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
